// ----- hw/rtl/owbm_pkg.sv -----
package owbm_pkg;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_RESET = 2'd1,
      KIND_WRITE = 2'd2,
      KIND_READ  = 2'd3
   } kind_type;

   typedef enum logic [8:0] {
      PH_IDLE    = 9'b000000001,
      PH_RST_LOW = 9'b000000010,
      PH_RST_REL = 9'b000000100,
      PH_PRES_W  = 9'b000001000,
      PH_PRES_L  = 9'b000010000,
      PH_WR_LOW  = 9'b000100000,
      PH_WR_HIGH = 9'b001000000,
      PH_RD_LOW  = 9'b010000000,
      PH_RD_REC  = 9'b100000000
   } phase_type;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 10;
   localparam int unsigned COUNT_WIDTH     = 10;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RESET_LOW     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RESET_RELEASE = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRESENCE_WAIT = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRESENCE_MAX  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SLOT_SHORT    = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SLOT_LONG     = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_READ_LOW      = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_READ_RECOVERY = 3'd7;

   localparam logic [9:0] RESET_LOW_DEFAULT     = 10'd650;
   localparam logic [7:0] RESET_RELEASE_DEFAULT = 8'd15;
   localparam logic [9:0] PRESENCE_WAIT_DEFAULT = 10'd100;
   localparam logic [9:0] PRESENCE_MAX_DEFAULT  = 10'd240;
   localparam logic [7:0] SLOT_SHORT_DEFAULT    = 8'd2;
   localparam logic [7:0] SLOT_LONG_DEFAULT     = 8'd60;
   localparam logic [7:0] READ_LOW_DEFAULT      = 8'd10;
   localparam logic [7:0] READ_RECOVERY_DEFAULT = 8'd50;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] write_data;
      logic       bus_level;
   } req_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic       presence_fail;
      logic [7:0] read_data;
   } rsp_type;

endpackage

// ----- hw/rtl/one_wire_bus_master.sv -----
// One-wire bus master stepped by microsecond ticks.
// Requests arrive on the req_ channel (valid/ready). A request is either a
// tick carrying the sampled bus level, or a command: reset with presence
// check, write byte or read byte. A command taken while idle starts the
// operation; a command taken while busy is ignored. Every tick advances the
// running operation by one microsecond.
// Each request yields exactly one response on the rsp_ channel, showing the
// bus drive and the status after that request. The response is computed in
// the cycle the request is taken and appears from the output register in
// the next cycle. One request per cycle is sustained while responses are
// taken; the single output register sets this, as req_ready is high whenever
// that register is empty or is being emptied in the same cycle.
// When the receiver stalls, the response holds and req_ready drops until it
// is taken.
// The user must write timing registers through csr_ only while the block
// is idle; the block does not enforce this. Synchronous reset returns the
// block to idle with the timing registers at their default values,
// presence failure and read data cleared, and no response pending.
module one_wire_bus_master (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  owbm_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output owbm_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_write_enable,
   input  logic [owbm_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [owbm_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   logic [9:0] reset_low_ff;
   logic [7:0] reset_release_ff;
   logic [9:0] presence_wait_ff;
   logic [9:0] presence_max_ff;
   logic [7:0] slot_short_ff;
   logic [7:0] slot_long_ff;
   logic [7:0] read_low_ff;
   logic [7:0] read_recovery_ff;

   owbm_pkg::phase_type                 phase_ff, phase_in;
   logic [owbm_pkg::COUNT_WIDTH-1:0]    tick_count_ff, tick_count_in;
   logic [2:0]                          bit_index_ff, bit_index_in;
   logic [7:0]                          shift_byte_ff, shift_byte_in;
   logic                                presence_flag_ff, presence_flag_in;
   logic [7:0]                          read_result_ff, read_result_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   owbm_pkg::rsp_type                   rsp_data_ff, rsp_data_in;

   logic                                accept;
   logic                                done;
   logic [owbm_pkg::COUNT_WIDTH-1:0]    count_inc;
   logic                                cur_bit;
   logic [9:0]                          slot_low_limit;
   logic [9:0]                          slot_high_limit;
   logic [7:0]                          sampled_byte;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign count_inc       = tick_count_ff + 10'd1;
   assign cur_bit         = shift_byte_ff[0];
   assign slot_low_limit  = cur_bit ? {2'b00, slot_short_ff} : {2'b00, slot_long_ff};
   assign slot_high_limit = cur_bit ? {2'b00, slot_long_ff} : {2'b00, slot_short_ff};
   assign sampled_byte    = (tick_count_ff == 10'd0)
                          ? (shift_byte_ff | (8'(req_data.bus_level) << bit_index_ff))
                          : shift_byte_ff;

   always_comb begin
      phase_in         = phase_ff;
      tick_count_in    = tick_count_ff;
      bit_index_in     = bit_index_ff;
      shift_byte_in    = shift_byte_ff;
      presence_flag_in = presence_flag_ff;
      read_result_in   = read_result_ff;
      done             = 1'b0;
      if (req_data.kind == owbm_pkg::KIND_TICK) begin
         unique case (phase_ff)
            owbm_pkg::PH_IDLE: begin
            end
            owbm_pkg::PH_RST_LOW: begin
               tick_count_in = count_inc;
               if (count_inc >= reset_low_ff) begin
                  tick_count_in = '0;
                  phase_in = (reset_release_ff == 8'd0) ? owbm_pkg::PH_PRES_W
                                                       : owbm_pkg::PH_RST_REL;
               end
            end
            owbm_pkg::PH_RST_REL: begin
               tick_count_in = count_inc;
               if (count_inc >= {2'b00, reset_release_ff}) begin
                  tick_count_in = '0;
                  phase_in = owbm_pkg::PH_PRES_W;
               end
            end
            owbm_pkg::PH_PRES_W: begin
               if (!req_data.bus_level) begin
                  tick_count_in = 10'd1;
                  if (presence_max_ff <= 10'd1) begin
                     presence_flag_in = 1'b1;
                     phase_in = owbm_pkg::PH_IDLE;
                     tick_count_in = '0;
                     done = 1'b1;
                  end else begin
                     phase_in = owbm_pkg::PH_PRES_L;
                  end
               end else begin
                  tick_count_in = count_inc;
                  if (count_inc >= presence_wait_ff) begin
                     presence_flag_in = 1'b1;
                     phase_in = owbm_pkg::PH_IDLE;
                     tick_count_in = '0;
                     done = 1'b1;
                  end
               end
            end
            owbm_pkg::PH_PRES_L: begin
               if (req_data.bus_level) begin
                  presence_flag_in = 1'b0;
                  phase_in = owbm_pkg::PH_IDLE;
                  tick_count_in = '0;
                  done = 1'b1;
               end else begin
                  tick_count_in = count_inc;
                  if (count_inc >= presence_max_ff) begin
                     presence_flag_in = 1'b1;
                     phase_in = owbm_pkg::PH_IDLE;
                     tick_count_in = '0;
                     done = 1'b1;
                  end
               end
            end
            owbm_pkg::PH_WR_LOW: begin
               tick_count_in = count_inc;
               if (count_inc >= slot_low_limit) begin
                  tick_count_in = '0;
                  phase_in = owbm_pkg::PH_WR_HIGH;
               end
            end
            owbm_pkg::PH_WR_HIGH: begin
               tick_count_in = count_inc;
               if (count_inc >= slot_high_limit) begin
                  shift_byte_in = shift_byte_ff >> 1;
                  tick_count_in = '0;
                  if (bit_index_ff == 3'd7) begin
                     bit_index_in = '0;
                     phase_in = owbm_pkg::PH_IDLE;
                     done = 1'b1;
                  end else begin
                     bit_index_in = bit_index_ff + 3'd1;
                     phase_in = owbm_pkg::PH_WR_LOW;
                  end
               end
            end
            owbm_pkg::PH_RD_LOW: begin
               tick_count_in = count_inc;
               if (count_inc >= {2'b00, read_low_ff}) begin
                  tick_count_in = '0;
                  phase_in = owbm_pkg::PH_RD_REC;
               end
            end
            owbm_pkg::PH_RD_REC: begin
               shift_byte_in = sampled_byte;
               tick_count_in = count_inc;
               if (count_inc >= {2'b00, read_recovery_ff}) begin
                  tick_count_in = '0;
                  if (bit_index_ff == 3'd7) begin
                     bit_index_in = '0;
                     read_result_in = sampled_byte;
                     phase_in = owbm_pkg::PH_IDLE;
                     done = 1'b1;
                  end else begin
                     bit_index_in = bit_index_ff + 3'd1;
                     phase_in = owbm_pkg::PH_RD_LOW;
                  end
               end
            end
            default: begin
               phase_in = owbm_pkg::PH_IDLE;
               tick_count_in = '0;
            end
         endcase
      end else if (phase_ff == owbm_pkg::PH_IDLE) begin
         tick_count_in = '0;
         bit_index_in = '0;
         unique case (req_data.kind)
            owbm_pkg::KIND_RESET: begin
               phase_in = owbm_pkg::PH_RST_LOW;
            end
            owbm_pkg::KIND_WRITE: begin
               shift_byte_in = req_data.write_data;
               phase_in = owbm_pkg::PH_WR_LOW;
            end
            default: begin
               shift_byte_in = '0;
               phase_in = owbm_pkg::PH_RD_LOW;
            end
         endcase
      end
   end

   always_comb begin
      rsp_data_in.drive_low     = (phase_in == owbm_pkg::PH_RST_LOW) ||
                                  (phase_in == owbm_pkg::PH_WR_LOW) ||
                                  (phase_in == owbm_pkg::PH_RD_LOW);
      rsp_data_in.busy_res      = (phase_in != owbm_pkg::PH_IDLE);
      rsp_data_in.done_res      = done;
      rsp_data_in.presence_fail = presence_flag_in;
      rsp_data_in.read_data     = read_result_in;
      rsp_valid_in = accept ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_low_ff     <= owbm_pkg::RESET_LOW_DEFAULT;
         reset_release_ff <= owbm_pkg::RESET_RELEASE_DEFAULT;
         presence_wait_ff <= owbm_pkg::PRESENCE_WAIT_DEFAULT;
         presence_max_ff  <= owbm_pkg::PRESENCE_MAX_DEFAULT;
         slot_short_ff    <= owbm_pkg::SLOT_SHORT_DEFAULT;
         slot_long_ff     <= owbm_pkg::SLOT_LONG_DEFAULT;
         read_low_ff      <= owbm_pkg::READ_LOW_DEFAULT;
         read_recovery_ff <= owbm_pkg::READ_RECOVERY_DEFAULT;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            owbm_pkg::CSR_RESET_LOW:     reset_low_ff     <= csr_wdata;
            owbm_pkg::CSR_RESET_RELEASE: reset_release_ff <= csr_wdata[7:0];
            owbm_pkg::CSR_PRESENCE_WAIT: presence_wait_ff <= csr_wdata;
            owbm_pkg::CSR_PRESENCE_MAX:  presence_max_ff  <= csr_wdata;
            owbm_pkg::CSR_SLOT_SHORT:    slot_short_ff    <= csr_wdata[7:0];
            owbm_pkg::CSR_SLOT_LONG:     slot_long_ff     <= csr_wdata[7:0];
            owbm_pkg::CSR_READ_LOW:      read_low_ff      <= csr_wdata[7:0];
            default:                     read_recovery_ff <= csr_wdata[7:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= owbm_pkg::PH_IDLE;
         tick_count_ff    <= '0;
         bit_index_ff     <= '0;
         shift_byte_ff    <= '0;
         presence_flag_ff <= 1'b0;
         read_result_ff   <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff         <= phase_in;
            tick_count_ff    <= tick_count_in;
            bit_index_ff     <= bit_index_in;
            shift_byte_ff    <= shift_byte_in;
            presence_flag_ff <= presence_flag_in;
            read_result_ff   <= read_result_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ----- hw/rtl/owbm_checker.sv -----
module owbm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input owbm_pkg::rsp_type rsp_data
);

   // An empty output register always takes a new request.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused while no response is pending");

   // Every accepted request produces a response in the next cycle.
   a_response_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted request produced no response");

   // A stalled response holds its value.
   a_response_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

   // An operation that finishes leaves the block idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.done_res) |-> !rsp_data.busy_res)
      else $error("done reported while still busy");

   // The bus is only driven while an operation runs.
   a_drive_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.drive_low) |-> rsp_data.busy_res)
      else $error("bus driven low while idle");

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker (.*);
